// File: rtl/dfs_pkg.sv
package dfs_pkg;

	localparam int MAX_DELIMITER_BYTES_DEF = 8;
	localparam int MAX_TEXT_BYTES = 65536;
	// last usable byte offset; positions are 16 bits wide
	localparam logic [15:0] LAST_OFFSET =
		(MAX_TEXT_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_TEXT_BYTES - 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam int PADDR_W = 4;
	localparam logic REG_DELIM_BYTES = 1'b0;
	localparam logic REG_DELIM_LEN = 1'b1;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [15:0] field_start;
		logic [15:0] field_length;
		logic        last_field;
		logic        overflow;
	} out_word_t;

	// results of one byte, in delivery order
	typedef struct packed {
		logic [1:0] count;
		out_word_t  first;
		out_word_t  second;
	} push_t;

endpackage

// File: rtl/dfs_core.sv
module dfs_core #(
	parameter int MAX_DELIMITER_BYTES = dfs_pkg::MAX_DELIMITER_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  dfs_pkg::in_word_t in_word,
	input  logic [63:0]      delim_bytes,
	input  logic [3:0]       delim_len,
	output dfs_pkg::push_t   push
);
	import dfs_pkg::*;

	localparam int WIN_W = 8 * MAX_DELIMITER_BYTES;

	logic [WIN_W-1:0] win_q, win_next;
	logic [15:0] pos_q, cfs_q;
	logic [3:0]  bsc_q, bsc_inc, dl_eff;
	logic        ovf_q, ovf_new;
	logic [16:0] cur_p1, end_off, len0, len1, start1;
	logic        match, cut;
	logic [MAX_DELIMITER_BYTES-1:0] lane_ok;
	logic [7:0]  want [MAX_DELIMITER_BYTES];

	function automatic logic [15:0] sat16(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	assign dl_eff = (delim_len > 4'(MAX_DELIMITER_BYTES)) ? 4'(MAX_DELIMITER_BYTES) : delim_len;
	assign win_next = WIN_W'({win_q, in_word.char_byte});
	assign bsc_inc = (bsc_q == 4'd15) ? bsc_q : bsc_q + 4'd1;
	assign cur_p1 = {1'b0, pos_q} + 17'd1;

	// lane k holds the byte k back; it must equal delimiter byte dl-1-k
	always_comb begin
		for (int k = 0; k < MAX_DELIMITER_BYTES; k++) begin
			want[k] = 8'h00;
			for (int j = 0; j < 8; j++) begin
				if (j == int'(dl_eff) - 1 - k)
					want[k] = delim_bytes[8*j +: 8];
			end
			lane_ok[k] = (k >= int'(dl_eff)) || (win_next[8*k +: 8] == want[k]);
		end
	end

	assign match = &lane_ok;
	assign cut = (dl_eff != 4'd0) && (bsc_inc >= dl_eff) && match;
	assign ovf_new = ovf_q | ((pos_q >= LAST_OFFSET) && !in_word.is_last);

	assign end_off = (cur_p1 >= {13'd0, dl_eff}) ? cur_p1 - {13'd0, dl_eff} : 17'd0;
	assign len0 = (end_off > {1'b0, cfs_q}) ? end_off - {1'b0, cfs_q} : 17'd0;
	assign start1 = cut ? cur_p1 : {1'b0, cfs_q};
	assign len1 = (!cut && cur_p1 > {1'b0, cfs_q}) ? cur_p1 - {1'b0, cfs_q} : 17'd0;

	always_comb begin
		out_word_t r0, r1;
		r0.field_start  = cfs_q;
		r0.field_length = sat16(len0);
		r0.last_field   = 1'b0;
		r0.overflow     = ovf_new;
		r1.field_start  = sat16(start1);
		r1.field_length = sat16(len1);
		r1.last_field   = 1'b1;
		r1.overflow     = ovf_new;
		push.count  = accept ? 2'({1'b0, cut} + {1'b0, in_word.is_last}) : 2'd0;
		push.first  = cut ? r0 : r1;
		push.second = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
			cfs_q <= '0;
			bsc_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (in_word.is_last) begin
				win_q <= '0;
				pos_q <= '0;
				cfs_q <= '0;
				bsc_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				win_q <= win_next;
				pos_q <= (pos_q < LAST_OFFSET) ? pos_q + 16'd1 : pos_q;
				ovf_q <= ovf_new;
				if (cut) begin
					cfs_q <= sat16(cur_p1);
					bsc_q <= 4'd0;
				end else begin
					bsc_q <= bsc_inc;
				end
			end
		end
	end

endmodule

// File: rtl/dfs_out_fifo.sv
module dfs_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  dfs_pkg::push_t     push,
	output logic               room,
	output logic               fld_valid,
	input  logic               fld_stall,
	output dfs_pkg::out_word_t fld_word
);
	import dfs_pkg::*;

	out_word_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic pop;

	assign fld_valid = (cnt_q != '0);
	assign fld_word  = mem_q[rd_ptr_q];
	assign pop       = fld_valid && !fld_stall;
	// two free slots needed: the last byte of a string can push two words
	assign room      = (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_ptr_q + FIFO_AW'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// File: rtl/delimiter_field_splitter_top.sv
// Delimiter field splitter.
// Input channel (char_valid/char_stall/char_word): one text byte per word,
// is_last marks the final byte of a string. Output channel
// (fld_valid/fld_stall/fld_word): one field per word, start offset and
// length, delimiter excluded, with last_field and overflow flags.
// Delimiter bytes (addr 0, 64 bits) and length (addr 8) are written over
// the APB port; the user must do that only while the block is idle, since
// the block does not enforce it. Length 0 turns splitting off. Throughput:
// one byte per cycle while char_stall is low. The window compare and field
// arithmetic sit between the state registers and a 4-entry result queue,
// so a field is queued when the byte that closes it is accepted. The final
// byte of a string that also ends a delimiter pushes two words (the field
// before it, then an empty last field). char_stall rises when the queue has
// fewer than two free entries, so a stalled receiver backs up into the
// input after a few words. Reset clears the window, position, field state
// and queue; the delimiter resets to length 1 with byte value zero.
module delimiter_field_splitter_top #(
	parameter int MAX_DELIMITER_BYTES = dfs_pkg::MAX_DELIMITER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte input
	input  logic                        char_valid,
	output logic                        char_stall,
	input  dfs_pkg::in_word_t           char_word,
	// field output
	output logic                        fld_valid,
	input  logic                        fld_stall,
	output dfs_pkg::out_word_t          fld_word,
	// APB config
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dfs_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);
	import dfs_pkg::*;

	logic [63:0] delim_bytes_q;
	logic [3:0]  delim_len_q;
	logic        cfg_wr, reg_sel, room, accept;
	push_t       push;

	// registers sit on 8-byte boundaries; bit 3 selects the register
	assign reg_sel = paddr[3];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (reg_sel == REG_DELIM_LEN) ? {60'd0, delim_len_q} : delim_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= '0;
			delim_len_q   <= 4'd1;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_DELIM_BYTES: delim_bytes_q <= pwdata;
				REG_DELIM_LEN:   delim_len_q   <= pwdata[3:0];
				default:         ;
			endcase
		end
	end

	// stall depends only on queue fill, never on char_valid
	assign char_stall = !room;
	assign accept     = char_valid && room;

	dfs_core #(
		.MAX_DELIMITER_BYTES(MAX_DELIMITER_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_word    (char_word),
		.delim_bytes(delim_bytes_q),
		.delim_len  (delim_len_q),
		.push       (push)
	);

	dfs_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.fld_valid(fld_valid),
		.fld_stall(fld_stall),
		.fld_word (fld_word)
	);

endmodule

// File: rtl/dfs_checker.sv
module dfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_stall,
	input dfs_pkg::in_word_t  char_word,
	input logic               fld_valid,
	input logic               fld_stall,
	input dfs_pkg::out_word_t fld_word
);

	// a stalled field word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fld_valid && fld_stall |=> fld_valid && $stable(fld_word))
		else $error("field word changed under stall");

	// the final byte of a string always yields a word next cycle
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && char_word.is_last |=> fld_valid)
		else $error("no field after final byte");

	// input backs up only while results are queued
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> fld_valid)
		else $error("input stalled with empty output");

	// a stalled input word stays on the port until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_word))
		else $error("input word changed under stall");

endmodule

bind delimiter_field_splitter_top dfs_checker u_dfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.char_valid(char_valid),
	.char_stall(char_stall),
	.char_word (char_word),
	.fld_valid (fld_valid),
	.fld_stall (fld_stall),
	.fld_word  (fld_word)
);

// File: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dfs_pkg::*;

	// register byte addresses: the delimiter register is 64 bits wide, so 8 bytes apart
	localparam logic [PADDR_W-1:0] ADDR_DELIM_BYTES = PADDR_W'(8 * REG_DELIM_BYTES);
	localparam logic [PADDR_W-1:0] ADDR_DELIM_LEN   = PADDR_W'(8 * REG_DELIM_LEN);

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_ALTERNATE
	} stall_mode_t;

	// directed row: one input word, plus up to two fields spelled out by hand
	typedef struct packed {
		in_word_t   w;
		logic [1:0] typed;
		out_word_t  first;
		out_word_t  second;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               char_valid;
	logic               char_stall;
	in_word_t           char_word;
	logic               fld_valid;
	logic               fld_stall = 1'b0;
	out_word_t          fld_word;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;

	delimiter_field_splitter_top DUT (
		.clk,
		.arst_n,
		.char_valid,
		.char_stall,
		.char_word,
		.fld_valid,
		.fld_stall,
		.fld_word,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	// 100 MHz
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Splitter prediction: our own copy of the delimiter registers and the
	// per-string state (shift window, next offset, open field start,
	// bytes since the last cut, sticky overflow).
	// ------------------------------------------------------------------
	logic [63:0] delim_word;
	logic [3:0]  delim_len;
	logic [63:0] win;
	int unsigned pos;
	int unsigned fld_start;
	logic [3:0]  since_cut;
	bit          ovf_seen;

	out_word_t   fields_due [$];   // fields predicted but not yet seen on the output

	int unsigned mismatches     = 0;
	int unsigned fields_checked = 0;
	int unsigned bytes_sent     = 0;
	int unsigned strings_sent   = 0;
	int unsigned settings_used  = 0;

	// sender burst shaping
	bit          steady_input = 1'b0;   // no gaps at all while set
	int unsigned burst_left   = 0;

	// receiver back-pressure
	bit          hold_req   = 1'b0;     // ask the receiver for one long hold-off
	bit          hold_taken = 1'b0;     // receiver side: hold-off already started
	int unsigned hold_left  = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left  = 0;

	function automatic logic [15:0] clip16(int unsigned v);
		return (v > 32'd65535) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic void restart_string();
		win       = '0;
		pos       = 0;
		fld_start = 0;
		since_cut = '0;
		ovf_seen  = 1'b0;
	endfunction

	// Advances the prediction by one byte; returns how many fields it closes.
	function automatic int split_byte(in_word_t w, output out_word_t r0, output out_word_t r1);
		int unsigned dl;
		int unsigned cur;
		int unsigned stop;
		int unsigned len;
		int unsigned start;
		bit          hit;
		bit          cut;
		out_word_t   field;
		int          n;
		r0  = '0;
		r1  = '0;
		n   = 0;
		cut = 1'b0;
		// lengths above the window size act as a full-window delimiter
		dl  = (delim_len > MAX_DELIMITER_BYTES_DEF) ? MAX_DELIMITER_BYTES_DEF : delim_len;
		cur = pos;
		win = {win[55:0], w.char_byte};
		if (since_cut != 4'd15)
			since_cut++;
		// offset saturates; a non-final byte landing on the last offset flags overflow
		if (pos < LAST_OFFSET)
			pos++;
		else if (!w.is_last)
			ovf_seen = 1'b1;
		// newest byte sits in the low byte and must equal the delimiter's last char
		hit = (dl > 0) && (since_cut >= dl);
		for (int k = 0; k < dl; k++)
			if (win[8*k +: 8] != delim_word[8*(dl-1-k) +: 8])
				hit = 1'b0;
		if (hit) begin
			stop = (cur + 1 >= dl) ? cur + 1 - dl : 0;
			len  = (stop > fld_start) ? stop - fld_start : 0;
			r0   = {clip16(fld_start), clip16(len), 1'b0, ovf_seen};
			n    = 1;
			fld_start = 32'(clip16(cur + 1));
			since_cut = '0;
			cut  = 1'b1;
		end
		if (w.is_last) begin
			// a delimiter on the final byte leaves an empty last field behind it
			start = cut ? cur + 1 : fld_start;
			len   = (cur + 1 > start) ? cur + 1 - start : 0;
			field = {clip16(start), clip16(len), 1'b1, ovf_seen};
			if (n == 0)
				r0 = field;
			else
				r1 = field;
			n++;
			restart_string();
		end
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Byte sender. Entered and left at a falling edge. Holds the word until
	// accepted, then either keeps valid up for the next word or opens a gap.
	// Hand-typed fields, when given, replace the predicted ones.
	// ------------------------------------------------------------------
	task automatic send_byte(in_word_t w, logic [1:0] typed = 2'd0,
			out_word_t t0 = '0, out_word_t t1 = '0);
		out_word_t r0;
		out_word_t r1;
		int        n;
		char_valid <= 1'b1;
		char_word  <= w;
		do
			@(posedge clk);
		while (char_stall);
		n = split_byte(w, r0, r1);
		if (typed != 2'd0) begin
			fields_due.push_back(t0);
			if (typed == 2'd2)
				fields_due.push_back(t1);
		end else begin
			if (n > 0)
				fields_due.push_back(r0);
			if (n > 1)
				fields_due.push_back(r1);
		end
		bytes_sent++;
		if (w.is_last)
			strings_sent++;
		@(negedge clk);
		if (!steady_input) begin
			if (burst_left == 0) begin
				// mostly short bursts, now and then a long unbroken run
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				                                         : $urandom_range(0, 12);
				char_valid <= 1'b0;
				repeat ($urandom_range(1, 5))
					@(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// APB write: setup cycle, then access; the register takes it at the edge
	// where psel, penable, pwrite and pready are all high.
	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == ADDR_DELIM_BYTES)
			delim_word = data;
		else
			delim_len = data[3:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_setting(logic [63:0] chars, logic [3:0] len);
		write_reg(ADDR_DELIM_BYTES, chars);
		write_reg(ADDR_DELIM_LEN, {60'd0, len});
		settings_used++;
	endtask

	// Drop valid, let every predicted field come out, then let the result
	// path settle before touching the registers.
	task automatic wait_drained();
		int unsigned spins;
		char_valid <= 1'b0;
		for (spins = 0; fields_due.size() != 0 && spins < 20000; spins++)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One well-formed string: full delimiters, loose delimiter chars (partial
	// and overlapping matches), a few plain letters and the odd random byte.
	task automatic send_random_string(int unsigned n);
		logic [7:0]  text [$];
		int unsigned dl;
		int unsigned roll;
		dl = (delim_len > 8) ? 8 : delim_len;
		while (text.size() < n) begin
			roll = $urandom_range(0, 99);
			if (dl > 0 && roll < 30) begin
				for (int j = 0; j < dl; j++)
					text.push_back(delim_word[8*j +: 8]);
			end else if (dl > 0 && roll < 60) begin
				text.push_back(delim_word[8*$urandom_range(0, dl - 1) +: 8]);
			end else if (roll < 90) begin
				text.push_back(8'(8'h61 + $urandom_range(0, 3)));
			end else begin
				text.push_back(8'($urandom_range(0, 255)));
			end
		end
		for (int i = 0; i < text.size(); i++)
			send_byte({text[i], i == text.size() - 1});
	endtask

	task automatic random_strings(int unsigned n_items);
		int unsigned base;
		base = bytes_sent;
		while (bytes_sent - base < n_items)
			send_random_string(($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
			                                               : $urandom_range(1, 40));
	endtask

	function automatic dir_row_t row(logic [7:0] b, logic l, logic [1:0] n = 2'd0,
			out_word_t a = '0, out_word_t c = '0);
		return {b, l, n, a, c};
	endfunction

	function automatic void report_bad(string what, out_word_t want, out_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns %s: expected start %0d len %0d last %0b ovf %0b,",
				$time, what, want.field_start, want.field_length, want.last_field,
				want.overflow, " got start %0d len %0d last %0b ovf %0b",
				got.field_start, got.field_length, got.last_field, got.overflow);
	endfunction

	// ------------------------------------------------------------------
	// Field receiver: stall pattern changes mode at random, and
	// on request holds off for a long counted stretch.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			fld_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(10, 150);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:      fld_stall <= 1'b0;
				STALL_LIGHT:     fld_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:     fld_stall <= ($urandom_range(0, 3) != 0);
				STALL_ALTERNATE: fld_stall <= !fld_stall;
			endcase
		end
	end

	// Every accepted field word goes against the oldest prediction.
	always @(posedge clk) begin : check_fields
		out_word_t want;
		if (arst_n && fld_valid && !fld_stall) begin
			if (fields_due.size() == 0) begin
				report_bad("field with nothing pending", '0, fld_word);
			end else begin
				want = fields_due.pop_front();
				fields_checked++;
				if (fld_word.field_start !== want.field_start
						|| fld_word.field_length !== want.field_length
						|| fld_word.last_field !== want.last_field
						|| fld_word.overflow !== want.overflow)
					report_bad("field mismatch", want, fld_word);
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("timeout with %0d fields outstanding", fields_due.size());
		$display("delimiter_field_splitter_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		dir_row_t dir_rows [23];

		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_word  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		delim_word = '0;
		delim_len  = 4'd1;
		restart_string();

		// Directed words under the reset delimiter (one zero byte). Fields given
		// by hand where obvious; the rest go through the predictor.
		dir_rows[0]  = row(8'hFF, 1'b1, 2'd1, {16'd0, 16'd1, 1'b1, 1'b0});
		// delimiter as the whole string: empty field, then empty last field
		dir_rows[1]  = row(8'h00, 1'b1, 2'd2, {16'd0, 16'd0, 1'b0, 1'b0},
		                                      {16'd1, 16'd0, 1'b1, 1'b0});
		dir_rows[2]  = row(8'h00, 1'b0, 2'd1, {16'd0, 16'd0, 1'b0, 1'b0});
		dir_rows[3]  = row(8'h00, 1'b0, 2'd1, {16'd1, 16'd0, 1'b0, 1'b0});
		dir_rows[4]  = row(8'h80, 1'b1, 2'd1, {16'd2, 16'd1, 1'b1, 1'b0});
		dir_rows[5]  = row(8'h41, 1'b0);
		dir_rows[6]  = row(8'h7F, 1'b0);
		dir_rows[7]  = row(8'h00, 1'b0, 2'd1, {16'd0, 16'd2, 1'b0, 1'b0});
		dir_rows[8]  = row(8'h01, 1'b0);
		dir_rows[9]  = row(8'hFE, 1'b1, 2'd1, {16'd3, 16'd2, 1'b1, 1'b0});
		dir_rows[10] = row(8'h55, 1'b0);
		dir_rows[11] = row(8'hAA, 1'b0);
		dir_rows[12] = row(8'h00, 1'b0);
		dir_rows[13] = row(8'h00, 1'b1);
		dir_rows[14] = row(8'h01, 1'b1, 2'd1, {16'd0, 16'd1, 1'b1, 1'b0});
		dir_rows[15] = row(8'h02, 1'b0);
		dir_rows[16] = row(8'h04, 1'b0);
		dir_rows[17] = row(8'h08, 1'b0);
		dir_rows[18] = row(8'h10, 1'b0);
		dir_rows[19] = row(8'h20, 1'b0);
		dir_rows[20] = row(8'h40, 1'b0);
		dir_rows[21] = row(8'h80, 1'b0);
		dir_rows[22] = row(8'hFF, 1'b1);

		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].first, dir_rows[i].second);
		wait_drained();

		// comma, with one long receiver hold-off while bytes keep coming so the
		// result queue fills and the input backs up
		apply_setting(64'h2C, 4'd1);
		steady_input = 1'b1;
		hold_req     = 1'b1;
		for (int i = 0; i < 80; i++)
			send_byte({(i % 2 == 1) ? 8'h2C : 8'(8'h41 + i), i == 79});
		steady_input = 1'b0;
		random_strings(200);
		wait_drained();

		// two-byte CR LF
		apply_setting(64'h0A0D, 4'd2);
		random_strings(200);
		wait_drained();

		// length zero: splitting off, each string comes back whole
		apply_setting({$urandom, $urandom}, 4'd0);
		random_strings(120);
		wait_drained();

		// "aaa": runs of the delimiter char check the non-overlapping rule
		apply_setting(64'h616161, 4'd3);
		random_strings(200);
		wait_drained();

		// full window of all-ones bytes
		apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		random_strings(150);
		wait_drained();

		// zero bytes, length beyond the window (clamped to eight)
		apply_setting(64'h0, 4'd15);
		random_strings(150);
		wait_drained();

		apply_setting({$urandom, $urandom}, 4'd9);
		random_strings(150);
		wait_drained();

		// random delimiters of random length; the loose-char picks make real matches
		repeat (3) begin
			apply_setting({$urandom, $urandom}, 4'($urandom_range(1, 8)));
			random_strings(100);
			wait_drained();
		end

		if (mismatches > 10)
			$display("%0d mismatches in total", mismatches);
		$display("ran %0d strings (%0d bytes) over %0d delimiters, %0d fields compared;",
			strings_sent, bytes_sent, settings_used, fields_checked);
		$display("splitting off, clamped lengths and a long output hold-off included");
		if (mismatches == 0 && fields_due.size() == 0)
			$display("delimiter_field_splitter_top regression: pass");
		else
			$display("delimiter_field_splitter_top regression: fail");
		$finish;
	end

endmodule
